>>> design/ppcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppcs_pkg
// Shared types and constants of the progressive pass coefficient splitter.
// ----------------------------------------------------------------------------
package ppcs_pkg;

	localparam int VAL_W      = 16;
	localparam int MAX_BLOCKS = 4;
	localparam int BLOCK_DIM  = 8;
	localparam int CFG_PASSES = 4;   // passes that the config registers describe

	// configuration register indexes
	localparam logic [1:0] CFG_PASS_COUNT  = 2'd0;
	localparam logic [1:0] CFG_PASS_SHIFTS = 2'd1;
	localparam logic [1:0] CFG_PASS_LIMITS = 2'd2;
	localparam logic [1:0] CFG_SO_MASK     = 2'd3;

	// per-pass settings handed to one cell
	typedef struct packed {
		logic [3:0] shift;
		logic [3:0] lim;
		logic       so;
	} ppcs_pcfg_t;

	// one coefficient as it travels down the row of cells
	typedef struct packed {
		logic [VAL_W-1:0] coeff;
		logic             neg;
		logic [VAL_W:0]   mag;
		logic [4:0]       col;
		logic [4:0]       row;
		logic [2:0]       bw;
		logic [2:0]       bh;
		logic             sal;
		logic [2:0]       n;
		logic [3:0]       done;
		logic             prev_so;
		logic [3:0]       prev_shift;
	} ppcs_tok_t;

	function automatic logic [2:0] clamp_blocks(input logic [2:0] b);
		logic [2:0] r;
		r = b;
		if (b == 3'd0) begin
			r = 3'd1;
		end else if ({3'b000, b} > 6'(MAX_BLOCKS)) begin
			r = 3'(MAX_BLOCKS);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/ppcs_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppcs_cell
// One pass of the splitter: works out this pass's value for the coefficient
// at its input and hands the coefficient on to the next cell through its output register.
// ----------------------------------------------------------------------------
module ppcs_cell import ppcs_pkg::*; #(
	parameter int NP  = 4,
	parameter int IDX = 0
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      adv,
	input  wire logic                      valid_in,
	input  wire ppcs_tok_t                 tok_in,
	input  wire logic [NP-1:0][VAL_W-1:0]  res_in,
	input  wire ppcs_pcfg_t                pcfg,
	output logic                           valid_q,
	output ppcs_tok_t                      tok_q,
	output logic [NP-1:0][VAL_W-1:0]       res_q
);

	logic [3:0]     lim_c;
	logic [6:0]     sq_w, sq_h, cov_w, cov_h;
	logic           skip_sal, in_sq, covered, keep;
	logic [VAL_W:0] m1, m2, sv;
	logic [VAL_W-1:0] val;
	ppcs_tok_t      tok_nx;
	logic [NP-1:0][VAL_W-1:0] res_nx;

	always_comb begin
		lim_c = (pcfg.lim > 4'(BLOCK_DIM)) ? 4'(BLOCK_DIM) : pcfg.lim;
		sq_w  = 7'(tok_in.bw) * 7'(lim_c);
		sq_h  = 7'(tok_in.bh) * 7'(lim_c);
		cov_w = 7'(tok_in.bw) * 7'(tok_in.done);
		cov_h = 7'(tok_in.bh) * 7'(tok_in.done);

		skip_sal = (pcfg.so || tok_in.prev_so) && (pcfg.so != tok_in.sal);
		in_sq    = (7'(tok_in.col) < sq_w) && (7'(tok_in.row) < sq_h);
		covered  = (7'(tok_in.col) < cov_w) && (7'(tok_in.row) < cov_h);
		keep     = !skip_sal && in_sq && !covered;

		// keep only the bits that the previous pass dropped
		m1 = tok_in.mag;
		if (tok_in.prev_shift != 4'd0) begin
			m1 = tok_in.mag & (((VAL_W+1)'(1) << tok_in.prev_shift) - (VAL_W+1)'(1));
		end
		m2  = m1 >> pcfg.shift;
		sv  = tok_in.neg ? (~m2 + (VAL_W+1)'(1)) : m2;
		val = keep ? sv[VAL_W-1:0] : '0;

		res_nx      = res_in;
		res_nx[IDX] = val;

		tok_nx = tok_in;
		if (!pcfg.so && pcfg.shift == 4'd0) begin
			tok_nx.done = lim_c;
		end
		tok_nx.prev_so    = pcfg.so;
		tok_nx.prev_shift = pcfg.shift;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_q <= tok_nx;
			res_q <= res_nx;
		end
	end

endmodule
`default_nettype wire

>>> design/ppcs_ser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppcs_ser
// Output register: takes the finished pass values of one coefficient and
// sends them out one transfer per cycle while m_tready is high, in pass order.
// ----------------------------------------------------------------------------
module ppcs_ser import ppcs_pkg::*; #(
	parameter int NP = 4
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic [NP-1:0][VAL_W-1:0]  in_res,
	input  wire logic [2:0]                in_n,
	input  wire logic [VAL_W-1:0]          in_coeff,
	output logic                           load_ok,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [VAL_W-1:0]               m_tdata,   // pass_value
	output logic [1:0]                     m_tuser,   // pass_index
	output logic                           m_tlast    // last_pass
);

	localparam int CNT_W = (NP > 1) ? $clog2(NP) : 1;

	logic [NP-1:0][VAL_W-1:0] res_q;
	logic [2:0]               n_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     valid_q;
	logic                     beat, is_last, load;
	logic [NP-1:0][VAL_W-1:0] res_ld;

	always_comb begin
		is_last = 4'(cnt_q) == (4'(n_q) - 4'd1);
		beat    = valid_q && m_tready;
		load_ok = !valid_q || (beat && is_last);
		load    = in_valid && load_ok;
		res_ld  = in_res;
		// a single pass copies the coefficient unchanged
		if (in_n == 3'd1) begin
			res_ld[0] = in_coeff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			cnt_q   <= '0;
		end else if (beat && is_last) begin
			valid_q <= 1'b0;
		end else if (beat) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_ld;
			n_q   <= in_n;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = res_q[cnt_q];
	assign m_tuser  = 2'(cnt_q);
	assign m_tlast  = is_last;

endmodule
`default_nettype wire

>>> design/progressive_pass_coeff_splitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// progressive_pass_coeff_splitter
// Splits each quantized AC coefficient into one value per progressive pass.
// ----------------------------------------------------------------------------
// A coefficient walks down a row of MAX_PASSES cells, one cell per pass and
// one cell per cycle unless the row is held; each cell adds its pass value and
// hands the coefficient on. The output register then sends n transfers (n =
// configured pass count, after saturation) one per cycle while m_tready is
// high, and takes the next coefficient only with the last transfer of the one
// before; a pass count of one thus gives one coefficient per cycle. Configuration
// writes are always ready; the pass count takes effect for coefficients accepted
// afterwards, the shifts, limits and mask at once; write them only while idle.
// ----------------------------------------------------------------------------
module progressive_pass_coeff_splitter import ppcs_pkg::*; #(
	parameter int MAX_PASSES = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// coefficient input
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [31:0]   s_tdata,   // coeff_value, col_pos, row_pos,
	                                      // blocks_wide, blocks_high
	input  wire logic          s_tuser,   // is_salient
	// pass results
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [VAL_W-1:0]   m_tdata,   // pass_value
	output logic [1:0]         m_tuser,   // pass_index
	output logic               m_tlast,   // last_pass
	// configuration writes
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [15:0]   cfg_data
);

	localparam int NP = MAX_PASSES;

	logic [2:0]  pass_count_q;
	logic [15:0] pass_shifts_q;
	logic [15:0] pass_limits_q;
	logic [3:0]  so_mask_q;

	ppcs_pcfg_t                pcfg  [NP];
	logic                      valid_c [NP+1];
	ppcs_tok_t                 tok_c   [NP+1];
	logic [NP-1:0][VAL_W-1:0]  res_c   [NP+1];
	logic                      adv, load_ok;
	logic [VAL_W-1:0]          coeff;
	logic [2:0]                n_ent;
	ppcs_tok_t                 tok_ent;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_count_q  <= 3'd1;
			pass_shifts_q <= 16'd0;
			pass_limits_q <= 16'h8888;
			so_mask_q     <= 4'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PASS_COUNT:  pass_count_q  <= cfg_data[2:0];
				CFG_PASS_SHIFTS: pass_shifts_q <= cfg_data;
				CFG_PASS_LIMITS: pass_limits_q <= cfg_data;
				CFG_SO_MASK:     so_mask_q     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < NP; i++) begin : g_pcfg
		if (i < CFG_PASSES) begin : g_reg
			assign pcfg[i].shift = pass_shifts_q[4*i +: 4];
			assign pcfg[i].lim   = pass_limits_q[4*i +: 4];
			assign pcfg[i].so    = so_mask_q[i];
		end else begin : g_zero
			assign pcfg[i] = '0;
		end
	end

	// entry: unpack and prepare the coefficient
	always_comb begin
		coeff = s_tdata[15:0];
		n_ent = pass_count_q;
		if (pass_count_q == 3'd0) begin
			n_ent = 3'd1;
		end else if (4'(pass_count_q) > 4'(MAX_PASSES)) begin
			n_ent = 3'(MAX_PASSES);
		end
		tok_ent.coeff      = coeff;
		tok_ent.neg        = coeff[VAL_W-1];
		tok_ent.mag        = coeff[VAL_W-1] ? (~{1'b1, coeff} + (VAL_W+1)'(1))
		                                    : {1'b0, coeff};
		tok_ent.col        = s_tdata[20:16];
		tok_ent.row        = s_tdata[25:21];
		tok_ent.bw         = clamp_blocks(s_tdata[28:26]);
		tok_ent.bh         = clamp_blocks(s_tdata[31:29]);
		tok_ent.sal        = s_tuser;
		tok_ent.n          = n_ent;
		tok_ent.done       = 4'd1;
		tok_ent.prev_so    = 1'b0;
		tok_ent.prev_shift = 4'd0;
	end

	assign tok_c[0]   = tok_ent;
	assign valid_c[0] = s_tvalid;
	assign res_c[0]   = '0;

	// the whole row moves together; hold while the output register is busy
	assign adv      = !valid_c[NP] || load_ok;
	assign s_tready = adv;

	for (genvar i = 0; i < NP; i++) begin : g_cell
		ppcs_cell #(
			.NP  (NP),
			.IDX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.valid_in (valid_c[i]),
			.tok_in   (tok_c[i]),
			.res_in   (res_c[i]),
			.pcfg     (pcfg[i]),
			.valid_q  (valid_c[i+1]),
			.tok_q    (tok_c[i+1]),
			.res_q    (res_c[i+1])
		);
	end

	ppcs_ser #(
		.NP (NP)
	) u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_c[NP]),
		.in_res   (res_c[NP]),
		.in_n     (tok_c[NP].n),
		.in_coeff (tok_c[NP].coeff),
		.load_ok  (load_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

>>> design/ppcs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppcs_checker
// Port-level checks on the pass result stream of the splitter.
// ----------------------------------------------------------------------------
module ppcs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic [1:0]  m_tuser,
	input wire logic        m_tlast
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// passes of one coefficient follow without gaps, in order
	a_next_pass: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && m_tuser == 2'($past(m_tuser) + 2'd1))
		else $error("pass sequence broken");

	// a new coefficient starts at pass zero
	a_first_pass: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid || m_tuser == 2'd0)
		else $error("coefficient did not start at pass zero");

endmodule

bind progressive_pass_coeff_splitter ppcs_checker u_ppcs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire
